// ===== design/tsps_pkg.sv =====
// tsps_pkg: command and slot-state codes, field widths and the
// controller/datapath interface types of the transmit slot pool.
// No dependencies.
package tsps_pkg;

    localparam int SLOT_FIELD_W = 2;
    localparam int LEN_W        = 10;
    localparam int BCNT_W       = 8;

    localparam logic [1:0] CMD_ACQUIRE  = 2'd0;
    localparam logic [1:0] CMD_COMMIT   = 2'd1;
    localparam logic [1:0] CMD_DONE     = 2'd2;
    localparam logic [1:0] CMD_REJECTED = 2'd3;

    localparam logic [1:0] ST_FREE  = 2'd0;
    localparam logic [1:0] ST_WRITE = 2'd1;
    localparam logic [1:0] ST_SEND  = 2'd2;
    localparam logic [1:0] ST_WAIT  = 2'd3;

    typedef struct packed {
        logic latch;
        logic exec;
        logic load_start;
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_read;
    } dp_stat_t;

endpackage

// ===== design/tsps_ctrl.sv =====
// tsps_ctrl: sequencing state machine of the transmit slot pool.
// Depends on tsps_pkg.
module tsps_ctrl
    import tsps_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output ctrl_cmd_t cmd,
    input  dp_stat_t  stat
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = stat.need_read ? S_READ : S_OUT;
            end
            S_READ:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!rsp_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_stall      = (state_reg != S_IDLE);
    assign rsp_valid      = (state_reg == S_OUT);
    assign cmd.latch      = (state_reg == S_IDLE) && req_valid;
    assign cmd.exec       = (state_reg == S_EXEC);
    assign cmd.load_start = (state_reg == S_READ);

endmodule

// ===== design/tsps_dpath.sv =====
// tsps_dpath: slot states, byte-count memory, send tracking and
// result registers of the transmit slot pool.
// Depends on tsps_pkg; driven by tsps_ctrl.
module tsps_dpath
    import tsps_pkg::*;
#(
    parameter int SLOTS     = 4,
    parameter int BUF_BYTES = 128
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  ctrl_cmd_t               cmd_ctl,
    output dp_stat_t                stat,
    input  logic [1:0]              cmd,
    input  logic [SLOT_FIELD_W-1:0] slot,
    input  logic [LEN_W-1:0]        length,
    output logic                    acquire_ok,
    output logic                    pool_full,
    output logic [SLOT_FIELD_W-1:0] granted_slot,
    output logic                    start_valid,
    output logic [SLOT_FIELD_W-1:0] start_slot,
    output logic [BCNT_W-1:0]       start_length,
    output logic                    queued
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [1:0]              cmd_reg;
    logic [SLOT_FIELD_W-1:0] slot_reg;
    logic [LEN_W-1:0]        length_reg;

    logic [1:0]              status_reg [SLOTS];
    logic [BCNT_W-1:0]       bcnt_mem [SLOTS];
    logic [BCNT_W-1:0]       rd_data_reg;
    logic                    active_reg;
    logic [SW-1:0]           send_idx_reg;

    logic                    acquire_ok_reg;
    logic                    pool_full_reg;
    logic [SLOT_FIELD_W-1:0] granted_slot_reg;
    logic                    start_valid_reg;
    logic [SLOT_FIELD_W-1:0] start_slot_reg;
    logic [BCNT_W-1:0]       start_length_reg;
    logic                    queued_reg;

    logic                    free_found;
    logic [SW-1:0]           free_idx;
    logic                    wait_found;
    logic [SW-1:0]           wait_idx;
    logic                    in_range;
    logic [SW-1:0]           slot_idx;
    logic                    commit_ok;
    logic                    commit_store;
    logic [BCNT_W-1:0]       clip_len;

    always_ff @(posedge clk)
    begin
        if (cmd_ctl.latch)
        begin
            cmd_reg    <= cmd;
            slot_reg   <= slot;
            length_reg <= length;
        end
    end

    // lowest-index free and waiting slots
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        wait_found = 1'b0;
        wait_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (status_reg[i] == ST_FREE)
            begin
                free_found = 1'b1;
                free_idx   = SW'(i);
            end
            if (status_reg[i] == ST_WAIT)
            begin
                wait_found = 1'b1;
                wait_idx   = SW'(i);
            end
        end
    end

    assign in_range     = (int'(slot_reg) < SLOTS);
    assign slot_idx     = SW'(slot_reg);
    assign commit_ok    = (cmd_reg == CMD_COMMIT) && in_range
                          && (status_reg[slot_idx] == ST_WRITE);
    assign commit_store = commit_ok && (length_reg != '0);
    assign clip_len     = (length_reg >= LEN_W'(BUF_BYTES))
                          ? BCNT_W'(BUF_BYTES - 1) : BCNT_W'(length_reg);

    assign stat.need_read = (cmd_reg == CMD_DONE) && wait_found;

    always_ff @(posedge clk)
    begin
        if (cmd_ctl.exec && commit_store)
        begin
            bcnt_mem[slot_idx] <= clip_len;
        end
        if (cmd_ctl.exec)
        begin
            rd_data_reg <= bcnt_mem[wait_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                status_reg[i] <= ST_FREE;
            end
            active_reg   <= 1'b0;
            send_idx_reg <= '0;
        end
        else if (cmd_ctl.exec)
        begin
            unique case (cmd_reg)
                CMD_ACQUIRE:
                begin
                    if (free_found)
                    begin
                        status_reg[free_idx] <= ST_WRITE;
                    end
                end
                CMD_COMMIT:
                begin
                    if (commit_ok)
                    begin
                        if (length_reg == '0)
                        begin
                            status_reg[slot_idx] <= ST_FREE;
                        end
                        else if (!active_reg)
                        begin
                            status_reg[slot_idx] <= ST_SEND;
                            active_reg           <= 1'b1;
                            send_idx_reg         <= slot_idx;
                        end
                        else
                        begin
                            status_reg[slot_idx] <= ST_WAIT;
                        end
                    end
                end
                CMD_DONE:
                begin
                    if (active_reg)
                    begin
                        status_reg[send_idx_reg] <= ST_FREE;
                    end
                    if (wait_found)
                    begin
                        status_reg[wait_idx] <= ST_SEND;
                        active_reg           <= 1'b1;
                        send_idx_reg         <= wait_idx;
                    end
                    else
                    begin
                        active_reg <= 1'b0;
                    end
                end
                CMD_REJECTED:
                begin
                    if (active_reg)
                    begin
                        status_reg[send_idx_reg] <= ST_FREE;
                        active_reg               <= 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_ctl.exec)
        begin
            acquire_ok_reg   <= (cmd_reg == CMD_ACQUIRE) && free_found;
            pool_full_reg    <= (cmd_reg == CMD_ACQUIRE) && !free_found;
            granted_slot_reg <= ((cmd_reg == CMD_ACQUIRE) && free_found)
                                ? SLOT_FIELD_W'(free_idx) : '0;
            queued_reg       <= commit_store && active_reg;
            if (commit_store && !active_reg)
            begin
                start_valid_reg  <= 1'b1;
                start_slot_reg   <= slot_reg;
                start_length_reg <= clip_len;
            end
            else if (stat.need_read)
            begin
                start_valid_reg  <= 1'b1;
                start_slot_reg   <= SLOT_FIELD_W'(wait_idx);
                start_length_reg <= '0;
            end
            else
            begin
                start_valid_reg  <= 1'b0;
                start_slot_reg   <= '0;
                start_length_reg <= '0;
            end
        end
        else if (cmd_ctl.load_start)
        begin
            start_length_reg <= rd_data_reg;
        end
    end

    assign acquire_ok   = acquire_ok_reg;
    assign pool_full    = pool_full_reg;
    assign granted_slot = granted_slot_reg;
    assign start_valid  = start_valid_reg;
    assign start_slot   = start_slot_reg;
    assign start_length = start_length_reg;
    assign queued       = queued_reg;

endmodule

// ===== design/tx_slot_pool_scheduler.sv =====
// tx_slot_pool_scheduler: top level of the transmit slot pool scheduler.
// Depends on tsps_pkg, tsps_ctrl and tsps_dpath.
//
// Usage:
//   Request channel (req_valid/req_stall, cmd, slot, length) carries one
//   event per transfer: acquire, commit, transfer done or start rejected.
//   Response channel (rsp_valid/rsp_stall) returns exactly one result per
//   event: acquire_ok, pool_full, granted_slot, start_valid, start_slot,
//   start_length and queued. Fields that do not apply to the event are 0.
//   Sequence: accept, execute, then the result is presented; a transfer
//   done that starts a waiting slot also passes through S_READ for the
//   registered read of the byte-count memory.
//   Events are handled one at a time: a new request is taken only after
//   the result of the last one has been taken.
//   req_stall is high from acceptance until the result is taken.
//   Reset marks every slot free and nothing sending; byte counts are held
//   in memory and are only read for slots written by a commit.
//   While rsp_stall is high the result is held unchanged and no new
//   request is taken.
module tx_slot_pool_scheduler
    import tsps_pkg::*;
#(
    parameter int SLOTS     = 4,
    parameter int BUF_BYTES = 128
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    req_valid,
    output logic                    req_stall,
    input  logic [1:0]              cmd,
    input  logic [SLOT_FIELD_W-1:0] slot,
    input  logic [LEN_W-1:0]        length,
    output logic                    rsp_valid,
    input  logic                    rsp_stall,
    output logic                    acquire_ok,
    output logic                    pool_full,
    output logic [SLOT_FIELD_W-1:0] granted_slot,
    output logic                    start_valid,
    output logic [SLOT_FIELD_W-1:0] start_slot,
    output logic [BCNT_W-1:0]       start_length,
    output logic                    queued
);

    ctrl_cmd_t ctl;
    dp_stat_t  stat;

    tsps_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (ctl),
        .stat      (stat)
    );

    tsps_dpath #(
        .SLOTS     (SLOTS),
        .BUF_BYTES (BUF_BYTES)
    ) u_dpath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_ctl      (ctl),
        .stat         (stat),
        .cmd          (cmd),
        .slot         (slot),
        .length       (length),
        .acquire_ok   (acquire_ok),
        .pool_full    (pool_full),
        .granted_slot (granted_slot),
        .start_valid  (start_valid),
        .start_slot   (start_slot),
        .start_length (start_length),
        .queued       (queued)
    );

endmodule

// ===== tb/tx_slot_pool_scheduler_checker.sv =====
`timescale 1ns / 100ps
// tx_slot_pool_scheduler_checker: watches the request and response channels,
// predicts each response from its own copy of the slot pool state and compares.
// Depends on tsps_pkg.
module tx_slot_pool_scheduler_checker
    import tsps_pkg::*;
#(
    parameter int SLOTS     = 4,
    parameter int BUF_BYTES = 128
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    req_valid,
    input  logic                    req_stall,
    input  logic [1:0]              cmd,
    input  logic [SLOT_FIELD_W-1:0] slot,
    input  logic [LEN_W-1:0]        length,
    input  logic                    rsp_valid,
    input  logic                    rsp_stall,
    input  logic                    acquire_ok,
    input  logic                    pool_full,
    input  logic [SLOT_FIELD_W-1:0] granted_slot,
    input  logic                    start_valid,
    input  logic [SLOT_FIELD_W-1:0] start_slot,
    input  logic [BCNT_W-1:0]       start_length,
    input  logic                    queued,
    output int                      mismatch_count,
    output int                      outstanding
);

    typedef struct packed {
        logic                    acquire_ok;
        logic                    pool_full;
        logic [SLOT_FIELD_W-1:0] granted_slot;
        logic                    start_valid;
        logic [SLOT_FIELD_W-1:0] start_slot;
        logic [BCNT_W-1:0]       start_length;
        logic                    queued;
    } slot_result_t;

    logic [1:0]              slot_state [SLOTS];
    logic [BCNT_W-1:0]       byte_count [SLOTS];
    logic                    tx_busy;
    logic [SLOT_FIELD_W-1:0] tx_slot;
    slot_result_t            result_fifo [$];
    slot_result_t            want;

    initial
    begin
        mismatch_count = 0;
        outstanding    = 0;
    end

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        mismatch_count++;
        $display("%0t mismatch: %s got %0d want %0d", $realtime, what, got, exp_val);
    endtask

    function automatic void launch_slot(input int idx, inout slot_result_t r);
        slot_state[idx] = ST_SEND;
        tx_busy         = 1'b1;
        tx_slot         = SLOT_FIELD_W'(idx);
        r.start_valid   = 1'b1;
        r.start_slot    = SLOT_FIELD_W'(idx);
        r.start_length  = byte_count[idx];
    endfunction

    function automatic slot_result_t schedule_event(input logic [1:0] c,
                                                    input logic [SLOT_FIELD_W-1:0] s,
                                                    input logic [LEN_W-1:0] l);
        slot_result_t     r;
        bit               found;
        logic [LEN_W-1:0] clipped;
        r     = '0;
        found = 1'b0;
        case (c)
            CMD_ACQUIRE:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!found && slot_state[i] == ST_FREE)
                    begin
                        found         = 1'b1;
                        slot_state[i] = ST_WRITE;
                        r.acquire_ok  = 1'b1;
                        r.granted_slot = SLOT_FIELD_W'(i);
                    end
                end
                if (!found)
                    r.pool_full = 1'b1;
            end
            CMD_COMMIT:
            begin
                if (s < SLOTS && slot_state[s] == ST_WRITE)
                begin
                    if (l == '0)
                        slot_state[s] = ST_FREE;
                    else
                    begin
                        clipped       = (l >= BUF_BYTES) ? LEN_W'(BUF_BYTES - 1) : l;
                        byte_count[s] = clipped[BCNT_W-1:0];
                        if (!tx_busy)
                            launch_slot(s, r);
                        else
                        begin
                            slot_state[s] = ST_WAIT;
                            r.queued      = 1'b1;
                        end
                    end
                end
            end
            CMD_DONE:
            begin
                if (tx_busy)
                begin
                    slot_state[tx_slot] = ST_FREE;
                    tx_busy             = 1'b0;
                end
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!found && slot_state[i] == ST_WAIT)
                    begin
                        found = 1'b1;
                        launch_slot(i, r);
                    end
                end
            end
            default:
            begin
                if (tx_busy)
                begin
                    slot_state[tx_slot] = ST_FREE;
                    tx_busy             = 1'b0;
                end
            end
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_state[i] = ST_FREE;
                byte_count[i] = '0;
            end
            tx_busy = 1'b0;
            tx_slot = '0;
            result_fifo.delete();
            outstanding <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (result_fifo.size() == 0)
                    report_mismatch("result transfer with nothing pending", 1, 0);
                else
                begin
                    want = result_fifo.pop_front();
                    if (acquire_ok !== want.acquire_ok)
                        report_mismatch("acquire_ok", acquire_ok, want.acquire_ok);
                    if (pool_full !== want.pool_full)
                        report_mismatch("pool_full", pool_full, want.pool_full);
                    if (granted_slot !== want.granted_slot)
                        report_mismatch("granted_slot", granted_slot, want.granted_slot);
                    if (start_valid !== want.start_valid)
                        report_mismatch("start_valid", start_valid, want.start_valid);
                    if (start_slot !== want.start_slot)
                        report_mismatch("start_slot", start_slot, want.start_slot);
                    if (start_length !== want.start_length)
                        report_mismatch("start_length", start_length, want.start_length);
                    if (queued !== want.queued)
                        report_mismatch("queued", queued, want.queued);
                end
            end
            if (req_valid && !req_stall)
                result_fifo.push_back(schedule_event(cmd, slot, length));
            outstanding <= result_fifo.size();
        end
    end

    final
    begin
        if (result_fifo.size() != 0)
            $display("%0d results still pending", result_fifo.size());
    end

endmodule

// ===== tb/tx_slot_pool_scheduler_tb.sv =====
`timescale 1ns / 100ps
// tx_slot_pool_scheduler_tb: drives directed and random slot pool events with
// random gaps and stalls, and gives the verdict. Depends on tsps_pkg, the
// scheduler RTL and tx_slot_pool_scheduler_checker.
module tx_slot_pool_scheduler_tb;
    import tsps_pkg::*;

    localparam int SLOTS        = 4;
    localparam int BUF_BYTES    = 128;
    localparam int RANDOM_ITEMS = 1127;
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 400000;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    req_valid;
    logic                    req_stall;
    logic [1:0]              cmd;
    logic [SLOT_FIELD_W-1:0] slot;
    logic [LEN_W-1:0]        length;
    logic                    rsp_valid;
    logic                    rsp_stall;
    logic                    acquire_ok;
    logic                    pool_full;
    logic [SLOT_FIELD_W-1:0] granted_slot;
    logic                    start_valid;
    logic [SLOT_FIELD_W-1:0] start_slot;
    logic [BCNT_W-1:0]       start_length;
    logic                    queued;
    int                      mismatch_count;
    int                      outstanding;
    int unsigned             cycle_count = 0;
    bit                      req_quiet = 1'b0;
    bit                      rsp_quiet = 1'b0;
    logic [SLOT_FIELD_W-1:0] open_slots [$];

    always #5 clk = ~clk;

    tx_slot_pool_scheduler #(.SLOTS(SLOTS), .BUF_BYTES(BUF_BYTES)) dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall),
        .cmd(cmd), .slot(slot), .length(length),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
        .acquire_ok(acquire_ok), .pool_full(pool_full), .granted_slot(granted_slot),
        .start_valid(start_valid), .start_slot(start_slot),
        .start_length(start_length), .queued(queued)
    );

    tx_slot_pool_scheduler_checker #(.SLOTS(SLOTS), .BUF_BYTES(BUF_BYTES)) checker_i (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall),
        .cmd(cmd), .slot(slot), .length(length),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
        .acquire_ok(acquire_ok), .pool_full(pool_full), .granted_slot(granted_slot),
        .start_valid(start_valid), .start_slot(start_slot),
        .start_length(start_length), .queued(queued),
        .mismatch_count(mismatch_count), .outstanding(outstanding)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[tx_slot_pool_scheduler] ERROR");
            $finish;
        end
    end

    // granted slots steer later commits toward well-formed acquire/commit pairs
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && rsp_valid && !rsp_stall && acquire_ok)
        begin
            open_slots.push_back(granted_slot);
            if (open_slots.size() > 8)
                void'(open_slots.pop_front());
        end
    end

    function automatic int draw_wait(inout bit quiet);
        if ($urandom_range(0, 39) == 0)
            quiet = !quiet;
        return quiet ? 0 : $urandom_range(0, 17);
    endfunction

    task automatic send_event(input logic [1:0] c, input logic [SLOT_FIELD_W-1:0] s,
                              input logic [LEN_W-1:0] l);
        int gap;
        gap = draw_wait(req_quiet);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        cmd       <= c;
        slot      <= s;
        length    <= l;
        @(posedge clk);
        while (req_stall) @(posedge clk);
    endtask

    task automatic send_random();
        int                      pick;
        int                      idx;
        logic [1:0]              c;
        logic [SLOT_FIELD_W-1:0] s;
        logic [LEN_W-1:0]        l;
        pick = $urandom_range(0, 99);
        s    = SLOT_FIELD_W'($urandom_range(0, 3));
        case ($urandom_range(0, 9))
            0:       l = '0;
            1:       l = LEN_W'($urandom_range(BUF_BYTES, 1023));
            2:       l = (pick[0]) ? LEN_W'(BUF_BYTES - 1) : LEN_W'(BUF_BYTES);
            3:       l = LEN_W'($urandom_range(0, 1023));
            default: l = LEN_W'($urandom_range(1, BUF_BYTES - 1));
        endcase
        if (pick < 30)
            c = CMD_ACQUIRE;
        else if (pick < 68)
        begin
            c = CMD_COMMIT;
            if (open_slots.size() != 0 && $urandom_range(0, 9) != 0)
            begin
                idx = $urandom_range(0, open_slots.size() - 1);
                s   = open_slots[idx];
                open_slots.delete(idx);
            end
        end
        else if (pick < 92)
            c = CMD_DONE;
        else
            c = CMD_REJECTED;
        send_event(c, s, l);
    endtask

    initial
    begin
        int hold;
        rsp_stall <= 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1) @(posedge clk);
        forever
        begin
            hold = draw_wait(rsp_quiet);
            if (hold > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            @(posedge clk);
            while (!rsp_valid) @(posedge clk);
        end
    end

    initial
    begin
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        cmd       <= CMD_ACQUIRE;
        slot      <= '0;
        length    <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // idle pool: done and rejected with nothing sending, commit to a free slot
        send_event(CMD_DONE, 2'd0, 10'd0);
        send_event(CMD_REJECTED, 2'd3, 10'd1023);
        send_event(CMD_COMMIT, 2'd2, 10'd5);
        // fill the pool, then overflow it
        repeat (SLOTS + 1) send_event(CMD_ACQUIRE, 2'd0, 10'd0);
        send_event(CMD_COMMIT, 2'd0, 10'd1023);
        send_event(CMD_COMMIT, 2'd1, 10'd128);
        send_event(CMD_COMMIT, 2'd2, 10'd0);
        send_event(CMD_COMMIT, 2'd3, 10'd127);
        send_event(CMD_COMMIT, 2'd3, 10'd9);
        send_event(CMD_DONE, 2'd1, 10'd0);
        send_event(CMD_REJECTED, 2'd0, 10'd0);
        // nothing sending, but slot 3 still waits
        send_event(CMD_DONE, 2'd2, 10'd512);
        send_event(CMD_ACQUIRE, 2'd3, 10'd0);
        send_event(CMD_COMMIT, 2'd0, 10'd1);
        send_event(CMD_DONE, 2'd0, 10'd0);
        send_event(CMD_DONE, 2'd0, 10'd0);
        send_event(CMD_ACQUIRE, 2'd0, 10'd0);
        send_event(CMD_COMMIT, 2'd0, 10'd255);
        send_event(CMD_REJECTED, 2'd1, 10'd682);

        repeat (RANDOM_ITEMS) send_random();
        req_valid <= 1'b0;

        // outstanding is a registered copy of the checker's pending count
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("[tx_slot_pool_scheduler] OK");
        else
            $display("[tx_slot_pool_scheduler] ERROR");
        $finish;
    end

endmodule
